### design/arp_cache_responder_assert.svh
// Assertion macros shared by the ARP cache responder checkers.
// Depends on nothing; included by the checker module.
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH
`define ACR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/arpc_pkg.sv
// Package for the ARP cache responder: payload structs and protocol constants.
// Depends on nothing.
package arpc_pkg;
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_HIT = 2'd2;
    localparam logic [1:0] ACT_MISS = 2'd3;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY = 16'd2;
    localparam logic [1:0] FOP_REQUEST = 2'd1;
    localparam logic [1:0] FOP_REPLY = 2'd2;
    localparam logic [15:0] ETH_HW_TYPE = 16'd1;
    localparam logic [15:0] IPV4_PROTO = 16'h0800;
    localparam logic [15:0] AGE_LIMIT_RESET = 16'd300;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0] REG_OWN_MAC = 2'd0;
    localparam logic [1:0] REG_OWN_IP = 2'd1;
    localparam logic [1:0] REG_AGE_LIMIT = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
    } arpc_req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  frame_opcode;
        logic [47:0] frame_dest_mac;
        logic [47:0] frame_target_mac;
        logic [31:0] frame_target_ip;
        logic [31:0] frame_sender_ip;
        logic [47:0] found_mac;
    } arpc_res_t;
endpackage

### design/arp_cache_responder.sv
// Top level of the ARP cache responder: APB registers, sequencer and cache.
// Depends on arpc_pkg.
//
// channel  | signals                | direction
// request  | start, busy, req       | in
// result   | done, res              | out
// config   | psel..pready, prdata   | in/out
//
// A frame that needs no cache access gives its result without a walk of the
// cache; a lookup, an insert or a tick walks every cache entry, one per cycle.
// The walk is set by the single cache memory read port. busy stays high
// through the result strobe, so the next request is taken in the cycle after it.
// The receiver cannot stall. The valid bits reset at once, so no clearing pass.
module arp_cache_responder #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  arpc_pkg::arpc_req_t req,
    output logic                done,
    output arpc_pkg::arpc_res_t res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import arpc_pkg::*;
    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_FINISH, S_OUT} state_t;
    state_t state_reg;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] age_limit_reg;
    arpc_req_t   req_reg;
    arpc_res_t   res_reg;
    arpc_res_t   res_next;
    logic        done_reg;
    logic [CW-1:0] cnt_reg;      // address being issued
    logic [CW-1:0] dcnt_reg;     // address of the data now on the read port
    logic        found_reg, free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [47:0] found_mac_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg;

    logic [31:0] mem_ip [CACHE_ENTRIES];
    logic [47:0] mem_mac [CACHE_ENTRIES];
    logic [15:0] mem_age [CACHE_ENTRIES];
    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;
    logic [15:0] rd_age_reg;

    logic wr_cfg;
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[4:3])
            REG_OWN_MAC:   prdata = {16'd0, own_mac_reg};
            REG_OWN_IP:    prdata = {32'd0, own_ip_reg};
            REG_AGE_LIMIT: prdata = {48'd0, age_limit_reg};
            default:       prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (wr_cfg && paddr[4:3] == REG_OWN_MAC)
            own_mac_reg <= pwdata[47:0];
        else if (wr_cfg && paddr[4:3] == REG_OWN_IP)
            own_ip_reg <= pwdata[31:0];
        else if (wr_cfg && paddr[4:3] == REG_AGE_LIMIT)
            age_limit_reg <= pwdata[15:0];
    end

    logic frame_ok, is_reply, is_request;
    assign frame_ok = req_reg.hw_type == ETH_HW_TYPE && req_reg.proto_type == IPV4_PROTO
                      && req_reg.hw_len == 8'd6 && req_reg.proto_len == 8'd4;
    assign is_reply = frame_ok && req_reg.arp_op == ARP_REPLY
                      && req_reg.target_mac == own_mac_reg;
    assign is_request = frame_ok && req_reg.arp_op == ARP_REQUEST
                        && req_reg.target_ip == own_ip_reg;

    logic [31:0] key_ip;
    assign key_ip = (req_reg.op == OP_LOOKUP) ? req_reg.target_ip : req_reg.sender_ip;

    // Read one entry per cycle; data arrives the cycle after the address.
    logic [IW-1:0] rd_addr, d_idx;
    logic [15:0] age_inc;
    logic d_valid, d_match, tick_write;
    assign rd_addr = cnt_reg[IW-1:0];
    assign d_idx = dcnt_reg[IW-1:0];
    assign d_valid = valid_reg[d_idx];
    assign d_match = d_valid && rd_ip_reg == key_ip;
    assign age_inc = (rd_age_reg == 16'hFFFF) ? rd_age_reg : rd_age_reg + 16'd1;
    assign tick_write = state_reg == S_SCAN && req_reg.op == OP_TICK && d_valid;

    always_ff @(posedge clk)
    begin
        rd_ip_reg <= mem_ip[rd_addr];
        rd_mac_reg <= mem_mac[rd_addr];
        rd_age_reg <= mem_age[rd_addr];
        if (tick_write)
            mem_age[d_idx] <= age_inc;
        else if (state_reg == S_FINISH && req_reg.op == OP_FRAME && !found_reg && free_reg)
        begin
            mem_ip[free_idx_reg] <= req_reg.sender_ip;
            mem_mac[free_idx_reg] <= req_reg.sender_mac;
            mem_age[free_idx_reg] <= 16'd0;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (req_reg.op == OP_FRAME && is_request)
        begin
            res_next.action = ACT_REPLY;
            res_next.frame_opcode = FOP_REPLY;
            res_next.frame_dest_mac = req_reg.sender_mac;
            res_next.frame_target_mac = req_reg.sender_mac;
            res_next.frame_target_ip = req_reg.sender_ip;
            res_next.frame_sender_ip = own_ip_reg;
        end
        else if (req_reg.op == OP_LOOKUP && found_reg)
        begin
            res_next.action = ACT_HIT;
            res_next.found_mac = found_mac_reg;
        end
        else if (req_reg.op == OP_LOOKUP)
        begin
            res_next.action = ACT_MISS;
            res_next.frame_opcode = FOP_REQUEST;
            res_next.frame_dest_mac = BCAST_MAC;
            res_next.frame_target_ip = req_reg.target_ip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            valid_reg <= '0;
            cnt_reg <= '0;
            dcnt_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            found_mac_reg <= '0;
            req_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_FINISH);
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        req_reg <= req;
                        cnt_reg <= '0;
                        found_reg <= 1'b0;
                        free_reg <= 1'b0;
                        state_reg <= S_READ;
                    end
                S_READ:
                    if (req_reg.op == OP_LOOKUP || req_reg.op == OP_TICK
                        || (req_reg.op == OP_FRAME && is_reply))
                    begin
                        dcnt_reg <= cnt_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else
                        state_reg <= S_FINISH;
                S_SCAN:
                begin
                    if (d_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        found_mac_reg <= rd_mac_reg;
                    end
                    if (!d_valid && !free_reg)
                    begin
                        free_reg <= 1'b1;
                        free_idx_reg <= d_idx;
                    end
                    if (tick_write && age_inc >= age_limit_reg)
                        valid_reg[d_idx] <= 1'b0;
                    dcnt_reg <= cnt_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (dcnt_reg == CW'(CACHE_ENTRIES - 1))
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    res_reg <= res_next;
                    if (req_reg.op == OP_FRAME && is_reply && !found_reg && free_reg)
                        valid_reg[free_idx_reg] <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign res = res_reg;
endmodule

### design/arp_cache_responder_checker.sv
// Port-level checker for the ARP cache responder, bound to the top level.
// Depends on arpc_pkg and arp_cache_responder_assert.svh.
`include "arp_cache_responder_assert.svh"
module arp_cache_responder_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input arpc_pkg::arpc_res_t res
);
    import arpc_pkg::*;
    `ACR_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `ACR_ASSERT_NEXT(a_done_free, clk, rst_n, done, !busy)
    `ACR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ACR_ASSERT_IMPL(a_hit_clean, clk, rst_n, done && res.action == ACT_HIT,
        res.frame_opcode == 2'd0)
endmodule

bind arp_cache_responder arp_cache_responder_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .res(res));

### verif/arp_cache_responder_test.sv
// Self-checking testbench for the ARP cache responder: directed table, then random traffic
// in several register settings, checked against a behavioral cache predictor.
// Depends on arpc_pkg and arp_cache_responder.
module arp_cache_responder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    localparam int ENTRIES = 64;
    localparam int POOL = 96;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        arpc_req_t item;
        bit        typed;
        arpc_res_t exp;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    arpc_req_t   req = '0;
    logic        done;
    arpc_res_t   res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    arp_cache_responder #(.CACHE_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the registers and the cache.
    logic [47:0] cfg_mac;
    logic [31:0] cfg_ip;
    logic [15:0] cfg_age_limit;
    bit          slot_valid [ENTRIES];
    logic [31:0] slot_ip [ENTRIES];
    logic [47:0] slot_mac [ENTRIES];
    logic [15:0] slot_age [ENTRIES];

    arpc_res_t   pending_results [$];
    logic [31:0] ip_pool [POOL];
    int          error_count = 0;
    int          item_count = 0;
    int          result_count = 0;
    int          hit_count = 0;
    int          reply_count = 0;
    int          idle_pct = 0;

    function automatic int find_slot(logic [31:0] ip);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_valid[i] && slot_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    function automatic arpc_res_t mk_reply(logic [47:0] mac, logic [31:0] ip, logic [31:0] own);
        arpc_res_t r;
        r = '0;
        r.action = ACT_REPLY;
        r.frame_opcode = FOP_REPLY;
        r.frame_dest_mac = mac;
        r.frame_target_mac = mac;
        r.frame_target_ip = ip;
        r.frame_sender_ip = own;
        return r;
    endfunction

    function automatic arpc_res_t mk_miss(logic [31:0] ip);
        arpc_res_t r;
        r = '0;
        r.action = ACT_MISS;
        r.frame_opcode = FOP_REQUEST;
        r.frame_dest_mac = BCAST_MAC;
        r.frame_target_ip = ip;
        return r;
    endfunction

    function automatic arpc_res_t mk_hit(logic [47:0] mac);
        arpc_res_t r;
        r = '0;
        r.action = ACT_HIT;
        r.found_mac = mac;
        return r;
    endfunction

    // Computes the result of one request and advances the cache copy.
    function automatic arpc_res_t predict_arp(arpc_req_t r);
        arpc_res_t out;
        bit ok;
        int idx;
        out = '0;
        case (r.op)
            OP_FRAME:
            begin
                ok = r.hw_type == ETH_HW_TYPE && r.proto_type == IPV4_PROTO &&
                     r.hw_len == 8'd6 && r.proto_len == 8'd4;
                if (ok && r.arp_op == ARP_REPLY && r.target_mac != cfg_mac)
                    ok = 0;
                if (ok && r.arp_op == ARP_REQUEST && r.target_ip != cfg_ip)
                    ok = 0;
                if (ok && r.arp_op == ARP_REPLY && find_slot(r.sender_ip) < 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            slot_valid[i] = 1;
                            slot_ip[i] = r.sender_ip;
                            slot_mac[i] = r.sender_mac;
                            slot_age[i] = '0;
                            break;
                        end
                    end
                end
                else if (ok && r.arp_op == ARP_REQUEST)
                    out = mk_reply(r.sender_mac, r.sender_ip, cfg_ip);
            end
            OP_LOOKUP:
            begin
                idx = find_slot(r.target_ip);
                out = (idx >= 0) ? mk_hit(slot_mac[idx]) : mk_miss(r.target_ip);
            end
            OP_TICK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i])
                    begin
                        if (slot_age[i] != 16'hFFFF)
                            slot_age[i]++;
                        if (slot_age[i] >= cfg_age_limit)
                            slot_valid[i] = 0;
                    end
                end
            end
            default: ;
        endcase
        return out;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        arpc_res_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, action", 64'(res.action), '0);
            else
            begin
                want = pending_results.pop_front();
                if (res.action != want.action)
                    report_mismatch("action", 64'(res.action), 64'(want.action));
                if (res.frame_opcode != want.frame_opcode)
                    report_mismatch("frame_opcode", 64'(res.frame_opcode),
                                    64'(want.frame_opcode));
                if (res.frame_dest_mac != want.frame_dest_mac)
                    report_mismatch("frame_dest_mac", 64'(res.frame_dest_mac),
                                    64'(want.frame_dest_mac));
                if (res.frame_target_mac != want.frame_target_mac)
                    report_mismatch("frame_target_mac", 64'(res.frame_target_mac),
                                    64'(want.frame_target_mac));
                if (res.frame_target_ip != want.frame_target_ip)
                    report_mismatch("frame_target_ip", 64'(res.frame_target_ip),
                                    64'(want.frame_target_ip));
                if (res.frame_sender_ip != want.frame_sender_ip)
                    report_mismatch("frame_sender_ip", 64'(res.frame_sender_ip),
                                    64'(want.frame_sender_ip));
                if (res.found_mac != want.found_mac)
                    report_mismatch("found_mac", 64'(res.found_mac), 64'(want.found_mac));
            end
        end
    end

    // Registers sit at byte addresses 8*i, since the MAC register is 48 bits wide.
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OWN_MAC: cfg_mac = value[47:0];
            REG_OWN_IP: cfg_ip = value[31:0];
            default: cfg_age_limit = value[15:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [47:0] mac, logic [31:0] ip, logic [15:0] limit);
        wait_drained();
        write_reg(REG_OWN_MAC, {16'h0, mac});
        write_reg(REG_OWN_IP, {32'h0, ip});
        write_reg(REG_AGE_LIMIT, {48'h0, limit});
    endtask

    // Holds start until the request is taken; start stays high for a following request unless an idle gap is drawn.
    task automatic send_request(arpc_req_t item, bit typed, arpc_res_t typed_exp);
        arpc_res_t p;
        req <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        p = predict_arp(item);
        pending_results.push_back(typed ? typed_exp : p);
        item_count++;
        if (p.action == ACT_HIT)
            hit_count++;
        if (p.action == ACT_REPLY)
            reply_count++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic arpc_req_t good_frame(logic [15:0] arp_op, logic [47:0] smac,
                                             logic [31:0] sip, logic [47:0] tmac,
                                             logic [31:0] tip);
        arpc_req_t r;
        r = '0;
        r.op = OP_FRAME;
        r.hw_type = ETH_HW_TYPE;
        r.proto_type = IPV4_PROTO;
        r.hw_len = 8'd6;
        r.proto_len = 8'd4;
        r.arp_op = arp_op;
        r.sender_mac = smac;
        r.sender_ip = sip;
        r.target_mac = tmac;
        r.target_ip = tip;
        return r;
    endfunction

    function automatic arpc_req_t lookup_of(logic [31:0] ip);
        arpc_req_t r;
        r = '0;
        r.op = OP_LOOKUP;
        r.target_ip = ip;
        return r;
    endfunction

    function automatic arpc_req_t random_request();
        arpc_req_t r;
        int pick;
        logic [31:0] ip;
        logic [255:0] noise;
        pick = $urandom_range(99);
        ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(POOL - 1)];
        if (pick < 35)
            r = good_frame(ARP_REPLY, rand48(), ip,
                           ($urandom_range(9) == 0) ? rand48() : cfg_mac, $urandom);
        else if (pick < 50)
            r = good_frame(ARP_REQUEST, rand48(), $urandom, rand48(),
                           ($urandom_range(5) == 0) ? $urandom : cfg_ip);
        else if (pick < 75)
            r = lookup_of(ip);
        else if (pick < 85)
        begin
            r = '0;
            r.op = OP_TICK;
        end
        else
        begin
            // Noise: every field random, or a well-formed frame with one field broken.
            noise = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(arpc_req_t)-1:0];
            if (pick < 93)
            begin
                r = good_frame(($urandom_range(1) ? ARP_REQUEST : ARP_REPLY), rand48(), ip,
                               cfg_mac, cfg_ip);
                case ($urandom_range(4))
                    0: r.hw_type = 16'($urandom);
                    1: r.proto_type = 16'($urandom);
                    2: r.hw_len = 8'($urandom);
                    3: r.proto_len = 8'($urandom);
                    default: r.arp_op = 16'($urandom);
                endcase
            end
        end
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(59) == 0)
            begin
                start <= 1'b0;
                wait_drained();
            end
            send_request(random_request(), 0, '0);
        end
        start <= 1'b0;
    endtask

    initial
    begin
        table_row_t rows [$];
        arpc_req_t r;
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [31:0] ip_a;
        logic [31:0] ip_b;

        cfg_mac = '0;
        cfg_ip = '0;
        cfg_age_limit = AGE_LIMIT_RESET;
        foreach (slot_valid[i])
            slot_valid[i] = 0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        mac_a = rand48();
        mac_b = rand48();
        ip_a = ip_pool[0];
        ip_b = ip_pool[1];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, run with the registers at their reset values.
        rows.push_back('{lookup_of(32'h0A00_0001), 1, mk_miss(32'h0A00_0001)});
        rows.push_back('{good_frame(ARP_REQUEST, 48'h0000_1111_2222, 32'h0A00_0002, '0, '0),
                         1, mk_reply(48'h0000_1111_2222, 32'h0A00_0002, '0)});
        rows.push_back('{good_frame(ARP_REQUEST, '1, '1, '1, '0), 1, mk_reply('1, '1, '0)});
        r = good_frame(ARP_REQUEST, mac_a, ip_a, '0, '0);
        r.hw_type = 16'hFFFF;
        rows.push_back('{r, 1, '0});
        r = good_frame(ARP_REQUEST, mac_a, ip_a, '0, '0);
        r.proto_type = '0;
        rows.push_back('{r, 1, '0});
        r = good_frame(ARP_REQUEST, mac_a, ip_a, '0, '0);
        r.hw_len = 8'hFF;
        rows.push_back('{r, 1, '0});
        r = good_frame(ARP_REQUEST, mac_a, ip_a, '0, '0);
        r.proto_len = '0;
        rows.push_back('{r, 1, '0});
        rows.push_back('{good_frame(16'd0, mac_a, ip_a, '0, '0), 1, '0});
        rows.push_back('{good_frame(16'hFFFF, mac_a, ip_a, '0, '0), 1, '0});
        r = '1;
        r.op = OP_UNUSED;
        rows.push_back('{r, 1, '0});
        rows.push_back('{good_frame(ARP_REPLY, mac_a, ip_a, '0, '0), 1, '0});
        rows.push_back('{lookup_of(ip_a), 1, mk_hit(mac_a)});
        rows.push_back('{good_frame(ARP_REPLY, mac_b, ip_a, '0, '0), 1, '0});
        rows.push_back('{lookup_of(ip_a), 1, mk_hit(mac_a)});
        rows.push_back('{good_frame(ARP_REPLY, mac_b, ip_b, 48'h1, '0), 1, '0});
        rows.push_back('{lookup_of(ip_b), 1, mk_miss(ip_b)});
        rows.push_back('{good_frame(ARP_REQUEST, mac_b, ip_b, '0, 32'h1), 1, '0});
        r = '0;
        r.op = OP_TICK;
        rows.push_back('{r, 1, '0});
        rows.push_back('{lookup_of(ip_a), 0, '0});
        rows.push_back('{good_frame(ARP_REPLY, '1, '1, '0, '0), 0, '0});
        rows.push_back('{lookup_of('1), 0, '0});
        foreach (rows[i])
            send_request(rows[i].item, rows[i].typed, rows[i].exp);
        start <= 1'b0;

        idle_pct = 0;
        configure(rand48(), $urandom, 16'd6);
        random_phase(180);

        idle_pct = 85;
        configure('1, '1, 16'hFFFF);
        random_phase(150);

        idle_pct = 25;
        configure('0, '0, 16'd1);
        random_phase(150);

        idle_pct = 0;
        configure(rand48(), $urandom, 16'($urandom_range(2, 40)));
        random_phase(150);

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Ran %0d requests (%0d results, %0d cache hits, %0d replies sent)",
                 item_count, result_count, hit_count, reply_count);
        $display("over four register settings, age limits 1 to 65535, with and without gaps.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("arp_cache_responder verification clean");
        else
            $display("arp_cache_responder verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("arp_cache_responder verification failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/arpc_pkg.sv
design/arp_cache_responder.sv
design/arp_cache_responder_checker.sv
verif/arp_cache_responder_test.sv
